@@ sv/bbr_pkg.sv @@
`default_nettype none

package bbr_pkg;

   localparam int NCH            = 3;
   localparam int CH_W           = 8;
   localparam int WIN            = 3;
   localparam int COL_SUM_W      = 10;
   localparam int WIN_SUM_W      = 12;
   localparam int OUT_COL_W      = 10;
   localparam int ROW_W          = 12;
   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 12;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int OUT_DEPTH      = 16;
   localparam int MAX_RESULTS    = 3;
   localparam int RES_CNT_W      = 2;
   localparam int BLUR_MULT_W    = 21;
   localparam int BLUR_SHIFT     = 24;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [BLUR_MULT_W-1:0]    BLUR_MULT    = 21'd1862271;
   localparam logic [FRAME_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

   typedef logic [NCH-1:0][CH_W-1:0] pixel_type;

   typedef struct packed {
      logic [CH_W-1:0] in_red;
      logic [CH_W-1:0] in_green;
      logic [CH_W-1:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [OUT_COL_W-1:0] out_col;
      logic [ROW_W-1:0]     out_row;
      logic [CH_W-1:0]      out_red;
      logic [CH_W-1:0]      out_green;
      logic [CH_W-1:0]      out_blue;
      logic                 run_last;
   } rsp_type;

   typedef struct packed {
      pixel_type                       mid;
      logic [NCH-1:0][COL_SUM_W-1:0]   sum;
   } column_type;

   typedef logic [NCH-1:0][WIN_SUM_W-1:0] window_sum_type;

   typedef struct packed {
      logic has_inner;
      logic has_edge;
      logic has_last;
      logic interior;
      logic row_ge1;
      logic row_ge2;
   } item_type;

   typedef struct packed {
      logic                 valid;
      logic [RES_CNT_W-1:0] cnt;
   } reserve_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]          cnt;
      rsp_type [MAX_RESULTS-1:0]     beat;
   } push_type;

   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_idx_type;

endpackage

`default_nettype wire

@@ sv/box_blur_3x3_rgb.sv @@
// Pipeline: results pass the registered stages B, C and D into the output queue and
// can be taken from the cycle after they are written; one result beat leaves per
// cycle while rsp_ready is high. Throughput: one pixel per cycle outside the last
// row while the queue has room; in the last row two beats per pixel (three at the
// row end), set by the single output beat per cycle. Reset: counters to zero, frame
// size to 640 x 480, window cleared, queue empty; the line buffer is not cleared.
`default_nettype none

module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire bbr_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output bbr_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [bbr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [bbr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bbr_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);

   import bbr_pkg::*;

   localparam int CNT_W  = $clog2(MAX_WIDTH);
   localparam int WC_W   = ((CNT_W > FRAME_WIDTH_W) ? CNT_W : FRAME_WIDTH_W) + 2;
   localparam int RC_W   = FRAME_HEIGHT_W + 1;
   localparam int XW     = (CNT_W > OUT_COL_W) ? CNT_W : OUT_COL_W;
   localparam int PROD_W = WIN_SUM_W + BLUR_MULT_W;
   localparam int LB_W   = 2 * NCH * CH_W;

   function automatic logic [RES_CNT_W-1:0] res_count(item_type it);
      return RES_CNT_W'(it.has_inner) + RES_CNT_W'(it.has_edge) + RES_CNT_W'(it.has_last);
   endfunction

   function automatic logic [OUT_COL_W-1:0] col_field(logic [CNT_W-1:0] col);
      logic [XW-1:0] ext;
      ext = XW'(col);
      return ext[OUT_COL_W-1:0];
   endfunction

   // configuration
   logic [FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff;
   logic                      csr_write;
   reg_idx_type               csr_idx;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_idx_type'(csr_paddr[CSR_ADDR_W-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_pwdata[FRAME_WIDTH_W-1:0];
            end
            REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_pwdata[FRAME_HEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_W'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_W'(frame_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // accept stage: position counters and result plan
   logic [CNT_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             req_fire;
   logic             room;
   logic [WC_W-1:0]  w_raw, w_eff, c_ext, c_next;
   logic [RC_W-1:0]  h_raw, h_eff, r_ext, r_next;
   logic             end_row, last_row;
   item_type         a_item;
   reserve_type      reserve;

   assign req_ready = room;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      w_raw  = WC_W'(frame_width_ff);
      w_eff  = (w_raw == '0) ? WC_W'(1) :
               ((w_raw > WC_W'(MAX_WIDTH)) ? WC_W'(MAX_WIDTH) : w_raw);
      h_raw  = RC_W'(frame_height_ff);
      h_eff  = (h_raw == '0) ? RC_W'(1) : h_raw;
      c_ext  = WC_W'(col_ff);
      c_next = c_ext + WC_W'(1);
      r_ext  = RC_W'(row_ff);
      r_next = r_ext + RC_W'(1);

      end_row  = (c_next >= w_eff);
      last_row = (r_next >= h_eff);

      a_item.row_ge1   = (row_ff != '0);
      a_item.row_ge2   = (r_ext >= RC_W'(2));
      a_item.has_inner = a_item.row_ge1 && (col_ff != '0);
      a_item.has_edge  = a_item.row_ge1 && end_row;
      a_item.has_last  = last_row;
      a_item.interior  = (c_ext >= WC_W'(2)) && (c_next <= w_eff) &&
                         a_item.row_ge2 && (r_next <= h_eff);

      reserve.valid = req_fire;
      reserve.cnt   = res_count(a_item);

      if (end_row) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + ROW_W'(1);
      end else begin
         col_in = col_ff + CNT_W'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_fire) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage B: line buffer read data, write back, new column
   logic             b_valid_ff;
   pixel_type        b_px_ff;
   logic [CNT_W-1:0] b_col_ff;
   logic [ROW_W-1:0] b_row_ff;
   item_type         b_item_ff;
   logic             fwd_ff;
   pixel_type        fwd_px_ff, fwd_mid_ff;
   logic [LB_W-1:0]  lb_rd_data;
   pixel_type        b_above, b_two, b_top, b_mid;
   column_type       new_col;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         fwd_ff     <= 1'b0;
      end else begin
         b_valid_ff <= req_fire;
         fwd_ff     <= b_valid_ff && (b_col_ff == col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         b_px_ff   <= {req_data.in_red, req_data.in_green, req_data.in_blue};
         b_col_ff  <= col_ff;
         b_row_ff  <= row_ff;
         b_item_ff <= a_item;
      end
      fwd_px_ff  <= b_px_ff;
      fwd_mid_ff <= b_mid;
   end

   bbr_line_ram #(
      .DEPTH (MAX_WIDTH),
      .AW    (CNT_W),
      .DW    (LB_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_col_ff),
      .wr_data ({b_mid, b_px_ff}),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (lb_rd_data)
   );

   always_comb begin
      b_two   = fwd_ff ? fwd_mid_ff : lb_rd_data[LB_W-1 -: NCH*CH_W];
      b_above = fwd_ff ? fwd_px_ff  : lb_rd_data[NCH*CH_W-1:0];
      b_top   = b_item_ff.row_ge2 ? b_two   : '0;
      b_mid   = b_item_ff.row_ge1 ? b_above : '0;
      new_col.mid = b_mid;
      for (int k = 0; k < NCH; k++) begin
         new_col.sum[k] = COL_SUM_W'(b_top[k]) + COL_SUM_W'(b_mid[k]) +
                          COL_SUM_W'(b_px_ff[k]);
      end
   end

   // window: row of column cells, newest at the top index
   column_type     cell_col  [WIN];
   window_sum_type cell_part [WIN+1];

   assign cell_part[0] = '0;

   for (genvar k = 0; k < WIN; k++) begin : g_cell
      column_type load;
      if (k == WIN - 1) begin : g_head
         assign load = new_col;
      end else begin : g_link
         assign load = cell_col[k+1];
      end
      bbr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (b_valid_ff),
         .col_in   (load),
         .col_out  (cell_col[k]),
         .part_in  (cell_part[k]),
         .part_out (cell_part[k+1])
      );
   end

   // stage C: window sums
   logic             c_valid_ff;
   pixel_type        c_px_ff;
   logic [CNT_W-1:0] c_col_ff;
   logic [ROW_W-1:0] c_row_ff;
   item_type         c_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_px_ff   <= b_px_ff;
      c_col_ff  <= b_col_ff;
      c_row_ff  <= b_row_ff;
      c_item_ff <= b_item_ff;
   end

   // stage D: scale and queue
   logic           d_valid_ff;
   window_sum_type d_sum_ff;
   pixel_type      d_center_ff, d_mid_ff, d_px_ff;
   logic [CNT_W-1:0] d_col_ff;
   logic [ROW_W-1:0] d_row_ff;
   item_type       d_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_sum_ff    <= cell_part[WIN];
      d_center_ff <= cell_col[1].mid;
      d_mid_ff    <= cell_col[WIN-1].mid;
      d_px_ff     <= c_px_ff;
      d_col_ff    <= c_col_ff;
      d_row_ff    <= c_row_ff;
      d_item_ff   <= c_item_ff;
   end

   logic [PROD_W-1:0] prod [NCH];
   pixel_type         blur, e1_px;
   rsp_type           e1, e2, e3;
   push_type          push;

   always_comb begin
      for (int k = 0; k < NCH; k++) begin
         prod[k] = PROD_W'(d_sum_ff[k]) * PROD_W'(BLUR_MULT);
         blur[k] = prod[k][BLUR_SHIFT +: CH_W];
      end
      e1_px = d_item_ff.interior ? blur : d_center_ff;

      e1.out_col   = col_field(d_col_ff - CNT_W'(1));
      e1.out_row   = d_row_ff - ROW_W'(1);
      e1.out_red   = e1_px[2];
      e1.out_green = e1_px[1];
      e1.out_blue  = e1_px[0];
      e1.run_last  = !d_item_ff.has_edge && !d_item_ff.has_last;

      e2.out_col   = col_field(d_col_ff);
      e2.out_row   = d_row_ff - ROW_W'(1);
      e2.out_red   = d_mid_ff[2];
      e2.out_green = d_mid_ff[1];
      e2.out_blue  = d_mid_ff[0];
      e2.run_last  = !d_item_ff.has_last;

      e3.out_col   = col_field(d_col_ff);
      e3.out_row   = d_row_ff;
      e3.out_red   = d_px_ff[2];
      e3.out_green = d_px_ff[1];
      e3.out_blue  = d_px_ff[0];
      e3.run_last  = 1'b1;

      push.cnt     = d_valid_ff ? res_count(d_item_ff) : '0;
      push.beat[0] = d_item_ff.has_inner ? e1 : (d_item_ff.has_edge ? e2 : e3);
      push.beat[1] = (d_item_ff.has_inner && d_item_ff.has_edge) ? e2 : e3;
      push.beat[2] = e3;
   end

   bbr_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .reserve   (reserve),
      .room      (room),
      .push      (push),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_col_advance: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (col_ff == '0) || (col_ff == $past(col_ff) + CNT_W'(1)))
      else $error("column counter skipped a position");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      req_fire && end_row && last_row |=> (col_ff == '0) && (row_ff == '0))
      else $error("counters did not wrap at frame end");

endmodule

`default_nettype wire

@@ sv/bbr_line_ram.sv @@
`default_nettype none

module bbr_line_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 48
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/bbr_cell.sv @@
`default_nettype none

module bbr_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    shift,
   input  wire bbr_pkg::column_type     col_in,
   output bbr_pkg::column_type          col_out,
   input  wire bbr_pkg::window_sum_type part_in,
   output bbr_pkg::window_sum_type      part_out
);

   import bbr_pkg::*;

   column_type col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift) begin
         col_ff <= col_in;
      end
   end

   always_comb begin
      for (int k = 0; k < NCH; k++) begin
         part_out[k] = part_in[k] + WIN_SUM_W'(col_ff.sum[k]);
      end
   end

   assign col_out = col_ff;

endmodule

`default_nettype wire

@@ sv/bbr_out_queue.sv @@
`default_nettype none

module bbr_out_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bbr_pkg::reserve_type reserve,
   output logic                      room,
   input  wire bbr_pkg::push_type    push,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output bbr_pkg::rsp_type          rsp_data
);

   import bbr_pkg::*;

   localparam int DEPTH = OUT_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   rsp_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pending_ff, pending_in;
   logic          pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign room      = ((CW+1)'(pending_ff) + (CW+1)'(MAX_RESULTS)) <= (CW+1)'(DEPTH);

   always_comb begin
      wr_ptr_in  = wr_ptr_ff + PW'(push.cnt);
      rd_ptr_in  = rd_ptr_ff + PW'(pop);
      count_in   = count_ff + CW'(push.cnt) - CW'(pop);
      pending_in = pending_ff + (reserve.valid ? CW'(reserve.cnt) : '0) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
         pending_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (RES_CNT_W'(k) < push.cnt) begin
            mem_ff[wr_ptr_ff + PW'(k)] <= push.beat[k];
         end
      end
   end

   a_count_within_pending: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pending_ff)
      else $error("queue holds more beats than were reserved");

   a_pending_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CW'(DEPTH))
      else $error("reserved beats exceed queue depth");

endmodule

`default_nettype wire
